FILE: rtl/pqc_pkg.sv
// Shared types, constants and a helper function for the PCM quantize and checksum block.
`default_nettype none
package pqc_pkg;

  // Bit-depth mode codes.
  localparam logic [1:0] MODE_16  = 2'd0;
  localparam logic [1:0] MODE_24  = 2'd1;
  localparam logic [1:0] MODE_32  = 2'd2;
  localparam logic [1:0] MODE_OFF = 2'd3;

  // Float scale factors as integer significands (32-bit mode scales by 2^31).
  localparam logic [23:0] SCALE_16 = 24'd32767;
  localparam logic [23:0] SCALE_24 = 24'd8388607;

  // Biased exponent at which the product's integer point sits at bit zero.
  localparam logic [7:0] EXP_POINT = 8'd150;

  // Saturation magnitudes per mode.
  localparam logic [32:0] POS_LIM_16 = 33'd32767;
  localparam logic [32:0] NEG_LIM_16 = 33'd32768;
  localparam logic [32:0] POS_LIM_24 = 33'd8388607;
  localparam logic [32:0] NEG_LIM_24 = 33'd8388608;
  localparam logic [32:0] POS_LIM_32 = 33'd2147483647;
  localparam logic [32:0] NEG_LIM_32 = 33'd2147483648;

  // Classified sample between the front end and the execution pipeline.
  typedef struct packed {
    logic        sign;
    logic [7:0]  expo;
    logic [23:0] mant;     // hidden bit included, zero when the sample is taken as zero
    logic [1:0]  mode;
    logic        restart;
  } item_t;

  // One byte fold of the running checksum.
  function automatic logic [31:0] fold_byte(input logic [31:0] sum, input logic [7:0] b);
    logic [31:0] s;
    s = {sum[23:0], 8'h00} ^ {24'h0, b};
    return s ^ {16'h0, s[31:16]};
  endfunction

endpackage
`default_nettype wire

FILE: rtl/pcm_quantize_checksum_top.sv
// Path: front-end register, queue, then the back-end stages to the checksum on the master side.
// Throughput: one item per cycle unless m_tready stalls; the checksum fold loops through one register.
// A four-entry queue lets the front end keep accepting while the output side stalls.
// Reset (rst, synchronous) empties all stages and the queue, clears the checksum
// and sets the depth mode to 16-bit.
`default_nettype none
module pcm_quantize_checksum_top
  import pqc_pkg::*;
(
  input  wire logic        clk,
  input  wire logic        rst,
  input  wire logic        cfg_wen,
  input  wire logic [1:0]  cfg_wdata,   // depth_mode
  input  wire logic        s_tvalid,
  output logic             s_tready,
  input  wire logic [31:0] s_tdata,     // [31:0] sample_bits
  input  wire logic        s_tuser,     // [0] restart
  output logic             m_tvalid,
  input  wire logic        m_tready,
  output logic [31:0]      m_tdata      // [31:0] checksum
);

  logic [1:0] depth_mode;
  logic       f_valid, f_ready, b_valid, b_ready;
  item_t      f_item, b_item;

  // Depth mode register.
  always_ff @(posedge clk) begin
    if (rst) begin
      depth_mode <= MODE_16;
    end else if (cfg_wen) begin
      depth_mode <= cfg_wdata;
    end
  end

  pqc_front u_front (
    .clk        (clk),
    .rst        (rst),
    .s_tvalid   (s_tvalid),
    .s_tready   (s_tready),
    .s_tdata    (s_tdata),
    .s_tuser    (s_tuser),
    .mode       (depth_mode),
    .item_valid (f_valid),
    .item_ready (f_ready),
    .item       (f_item)
  );

  pqc_queue u_queue (
    .clk       (clk),
    .rst       (rst),
    .in_valid  (f_valid),
    .in_ready  (f_ready),
    .in_item   (f_item),
    .out_valid (b_valid),
    .out_ready (b_ready),
    .out_item  (b_item)
  );

  pqc_back u_back (
    .clk        (clk),
    .rst        (rst),
    .item_valid (b_valid),
    .item_ready (b_ready),
    .item       (b_item),
    .m_tvalid   (m_tvalid),
    .m_tready   (m_tready),
    .m_tdata    (m_tdata)
  );

endmodule
`default_nettype wire

FILE: rtl/pqc_front.sv
// Front end: accepts samples, decodes the float fields and flushes NaN and subnormals.
`default_nettype none
module pqc_front
  import pqc_pkg::*;
(
  input  wire logic        clk,
  input  wire logic        rst,
  input  wire logic        s_tvalid,
  output logic             s_tready,
  input  wire logic [31:0] s_tdata,
  input  wire logic        s_tuser,
  input  wire logic [1:0]  mode,
  output logic             item_valid,
  input  wire logic        item_ready,
  output item_t            item
);

  logic  full;
  item_t held;

  assign s_tready   = !full || item_ready;
  assign item_valid = full;
  assign item       = held;

  // Valid flag of the classify register.
  always_ff @(posedge clk) begin
    if (rst) begin
      full <= 1'b0;
    end else if (s_tready) begin
      full <= s_tvalid;
    end
  end

  // Classify the sample: zero, subnormal and NaN all become a zero significand.
  always_ff @(posedge clk) begin
    if (s_tvalid && s_tready) begin
      held.sign    <= s_tdata[31];
      held.mode    <= mode;
      held.restart <= s_tuser;
      if (s_tdata[30:23] == 8'h00 || (s_tdata[30:23] == 8'hFF && s_tdata[22:0] != 23'd0)) begin
        held.expo <= 8'h00;
        held.mant <= 24'd0;
      end else begin
        held.expo <= s_tdata[30:23];
        held.mant <= {1'b1, s_tdata[22:0]};
      end
    end
  end

endmodule
`default_nettype wire

FILE: rtl/pqc_queue.sv
// Four-entry queue that decouples the front end from the execution pipeline.
`default_nettype none
module pqc_queue
  import pqc_pkg::*;
(
  input  wire logic  clk,
  input  wire logic  rst,
  input  wire logic  in_valid,
  output logic       in_ready,
  input  wire item_t in_item,
  output logic       out_valid,
  input  wire logic  out_ready,
  output item_t      out_item
);

  localparam int unsigned DEPTH = 4;
  localparam int unsigned AW    = $clog2(DEPTH);

  item_t         mem [DEPTH];
  logic [AW-1:0] wr_ptr;
  logic [AW-1:0] rd_ptr;
  logic [AW:0]   count;
  logic          push;
  logic          pop;

  assign in_ready  = count != (AW+1)'(DEPTH);
  assign out_valid = count != '0;
  assign push      = in_valid && in_ready;
  assign pop       = out_valid && out_ready;
  assign out_item  = mem[rd_ptr];

  // Pointers and fill count.
  always_ff @(posedge clk) begin
    if (rst) begin
      wr_ptr <= '0;
      rd_ptr <= '0;
      count  <= '0;
    end else begin
      if (push) wr_ptr <= wr_ptr + 1'b1;
      if (pop)  rd_ptr <= rd_ptr + 1'b1;
      if (push && !pop) begin
        count <= count + 1'b1;
      end else if (pop && !push) begin
        count <= count - 1'b1;
      end
    end
  end

  // Storage.
  always_ff @(posedge clk) begin
    if (push) mem[wr_ptr] <= in_item;
  end

endmodule
`default_nettype wire

FILE: rtl/pqc_back.sv
// Execution pipeline: scale, round, truncate and clamp, then fold bytes into the checksum.
`default_nettype none
module pqc_back
  import pqc_pkg::*;
(
  input  wire logic        clk,
  input  wire logic        rst,
  input  wire logic        item_valid,
  output logic             item_ready,
  input  wire item_t       item,
  output logic             m_tvalid,
  input  wire logic        m_tready,
  output logic [31:0]      m_tdata
);

  // Stage valids and advance enables.
  logic v1, v2, v3, v4;
  logic en1, en2, en3, en4;

  assign en4        = !v4 || m_tready;
  assign en3        = !v3 || en4;
  assign en2        = !v2 || en3;
  assign en1        = !v1 || en2;
  assign item_ready = en1;
  assign m_tvalid   = v4;

  logic [55:0] p1, p2;
  logic [7:0]  e1, e2;
  logic        sg1, sg2;
  logic [1:0]  md1, md2, md3;
  logic        rs1, rs2, rs3;
  logic [31:0] q3;
  logic [31:0] running_sum;
  logic [31:0] out_sum;

  always_ff @(posedge clk) begin
    if (rst) begin
      v1 <= 1'b0;
      v2 <= 1'b0;
      v3 <= 1'b0;
      v4 <= 1'b0;
    end else begin
      if (en1) v1 <= item_valid;
      if (en2) v2 <= v1;
      if (en3) v3 <= v2;
      if (en4) v4 <= v3;
    end
  end

  // Stage 1: exact product of the significand and the scale.
  logic [55:0] prod;
  always_comb begin
    unique case (item.mode)
      MODE_16: prod = 56'(item.mant) * 56'(SCALE_16);
      MODE_24: prod = 56'(item.mant) * 56'(SCALE_24);
      default: prod = {1'b0, item.mant, 31'd0};
    endcase
  end

  always_ff @(posedge clk) begin
    if (en1 && item_valid) begin
      p1  <= prod;
      e1  <= item.expo;
      sg1 <= item.sign;
      md1 <= item.mode;
      rs1 <= item.restart;
    end
  end

  // Stage 2: round the product to 24 significant bits, ties to even.
  logic [5:0]  rpos;
  logic [55:0] rmask;
  logic [55:0] rone;
  logic [55:0] rlow;
  logic [55:0] rhalf;
  logic        rup;
  logic [55:0] rounded;
  always_comb begin
    unique case (md1)
      MODE_16: rpos = p1[38] ? 6'd15 : 6'd14;
      MODE_24: rpos = p1[46] ? 6'd23 : 6'd22;
      default: rpos = 6'd0;
    endcase
    rone    = 56'd1 << rpos;
    rmask   = rone - 56'd1;
    rlow    = p1 & rmask;
    rhalf   = rone >> 1;
    rup     = (rpos != 6'd0) && (rlow > rhalf || (rlow == rhalf && (p1 & rone) != 56'd0));
    rounded = (p1 & ~rmask) + (rup ? rone : 56'd0);
  end

  always_ff @(posedge clk) begin
    if (en2 && v1) begin
      p2  <= rounded;
      e2  <= e1;
      sg2 <= sg1;
      md2 <= md1;
      rs2 <= rs1;
    end
  end

  // Stage 3: truncate toward zero by the exponent, then saturate to the mode's range.
  logic [7:0]  sh;
  logic        sat;
  logic [55:0] mag;
  logic [32:0] lim;
  logic [32:0] qmag;
  logic [32:0] qneg;
  always_comb begin
    sat = e2 >= EXP_POINT;
    sh  = EXP_POINT - e2;
    mag = (sh >= 8'd56) ? 56'd0 : (p2 >> sh);
    unique case (md2)
      MODE_16: lim = sg2 ? NEG_LIM_16 : POS_LIM_16;
      MODE_24: lim = sg2 ? NEG_LIM_24 : POS_LIM_24;
      default: lim = sg2 ? NEG_LIM_32 : POS_LIM_32;
    endcase
    qmag = (sat || mag > {23'd0, lim}) ? lim : mag[32:0];
    qneg = ~qmag + 33'd1;
  end

  always_ff @(posedge clk) begin
    if (en3 && v2) begin
      q3  <= sg2 ? qneg[31:0] : qmag[31:0];
      md3 <= md2;
      rs3 <= rs2;
    end
  end

  // Stage 4: fold the low bytes, least significant first, into the checksum.
  logic [2:0]  nbytes;
  logic [31:0] fsum;
  always_comb begin
    unique case (md3)
      MODE_16: nbytes = 3'd2;
      MODE_24: nbytes = 3'd3;
      MODE_32: nbytes = 3'd4;
      default: nbytes = 3'd0;
    endcase
    fsum = rs3 ? 32'd0 : running_sum;
    for (int i = 0; i < 4; i++) begin
      if (3'(i) < nbytes) fsum = fold_byte(fsum, q3[8*i +: 8]);
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      running_sum <= 32'd0;
    end else if (en4 && v3) begin
      running_sum <= fsum;
    end
  end

  always_ff @(posedge clk) begin
    if (en4 && v3) out_sum <= fsum;
  end

  assign m_tdata = out_sum;

endmodule
`default_nettype wire

FILE: rtl/pqc_checker.sv
// Port-level checker for the PCM quantize and checksum block, bound to the top level.
`default_nettype none
module pqc_checker (
  input wire logic        clk,
  input wire logic        rst,
  input wire logic        s_tready,
  input wire logic        m_tvalid,
  input wire logic        m_tready,
  input wire logic [31:0] m_tdata
);

  // Reset leaves no result pending.
  a_reset_empty: assert property (@(posedge clk) rst |=> !m_tvalid)
    else $error("result valid right after reset");

  // Reset leaves the input side open.
  a_reset_ready: assert property (@(posedge clk) rst |=> s_tready)
    else $error("input not ready right after reset");

  // A stalled result holds.
  a_hold: assert property (@(posedge clk) disable iff (rst)
    m_tvalid && !m_tready |=> m_tvalid && $stable(m_tdata))
    else $error("stalled result changed");

  // No result can appear in the first cycle after reset.
  a_no_spurious: assert property (@(posedge clk) disable iff (rst)
    $past(rst) |-> !m_tvalid)
    else $error("result appeared without an input item");

endmodule

bind pcm_quantize_checksum_top pqc_checker u_pqc_checker (
  .clk      (clk),
  .rst      (rst),
  .s_tready (s_tready),
  .m_tvalid (m_tvalid),
  .m_tready (m_tready),
  .m_tdata  (m_tdata)
);
`default_nettype wire
